// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared codes and types for the linear key/value table.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int COUNT_FIELD_WIDTH = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

endpackage

// ----- rtl/lkv_mem.sv -----
// ----------------------------------------------------------------------------
// lkv_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lkv_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/linear_key_value_table.sv -----
// ----------------------------------------------------------------------------
// linear_key_value_table
// Unique-key table with insert, lookup and remove by linear search.
// ----------------------------------------------------------------------------
// Each word is one operation. The block takes one word at a time: after
// acceptance it reads every slot of the entry memory, one slot per cycle
// through its single read port, and checks it in one shared key comparator,
// noting the matching slot and the lowest free slot. An update state then
// writes the memory and the entry count, and a done state loads the result
// register once the output register is free. The registered read adds a
// step to the scan. in_ready returns as soon as the result is loaded, even
// while it waits to be taken. A result still waiting in the output register
// holds the next one back until it is taken. After reset the block clears
// the slot valid flags in the memory, with in_ready low.
// ----------------------------------------------------------------------------
module linear_key_value_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic [31:0] out_found_value,
  output logic [4:0]  out_entry_count
);

  localparam int FW = lkv_pkg::FIELD_WIDTH;
  localparam int KW = (KEY_WIDTH < FW) ? KEY_WIDTH : FW;
  localparam int VW = (VALUE_WIDTH < FW) ? VALUE_WIDTH : FW;
  localparam int MW = 1 + KW + VW;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > lkv_pkg::COUNT_FIELD_WIDTH) ? CW : lkv_pkg::COUNT_FIELD_WIDTH;
  localparam logic [AW:0] SCAN_END  = (AW + 1)'(TABLE_DEPTH);
  localparam logic [AW:0] CLEAR_END = (AW + 1)'(TABLE_DEPTH - 1);

  lkv_pkg::state_t state_r, state_nxt;

  logic [AW:0]   sc_r;
  logic          rd_pend_r;
  logic [AW-1:0] rd_idx_r;
  logic [1:0]    op_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic          found_r;
  logic [AW-1:0] slot_r;
  logic [VW-1:0] fval_r;
  logic          free_found_r;
  logic [AW-1:0] free_slot_r;
  logic [CW-1:0] count_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_hit_r;
  logic [31:0] out_found_value_r;
  logic [4:0]  out_entry_count_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic          mem_re;
  logic [MW-1:0] mem_rdata;

  logic          rd_used;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;
  logic          key_match;
  logic          do_insert;
  logic          do_remove;
  logic          accept;
  logic          load_out;
  logic [1:0]    res_status;
  logic          res_hit;
  logic [31:0]   res_found;
  logic [EW-1:0] count_ext;

  lkv_mem #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(MW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(sc_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  assign rd_used   = mem_rdata[MW-1];
  assign rd_key    = mem_rdata[MW-2 -: KW];
  assign rd_val    = mem_rdata[VW-1:0];
  assign key_match = rd_used && (rd_key == key_r);

  assign do_insert = (op_r == lkv_pkg::OP_INSERT) && !found_r && free_found_r;
  assign do_remove = (op_r == lkv_pkg::OP_REMOVE) && found_r;

  assign in_ready = (state_r == lkv_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == lkv_pkg::S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = sc_r[AW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    case (state_r)
      lkv_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (sc_r == CLEAR_END) begin
          state_nxt = lkv_pkg::S_IDLE;
        end
      end
      lkv_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = lkv_pkg::S_SCAN;
        end
      end
      lkv_pkg::S_SCAN: begin
        mem_re = (sc_r != SCAN_END);
        if (sc_r == SCAN_END) begin
          state_nxt = lkv_pkg::S_UPDATE;
        end
      end
      lkv_pkg::S_UPDATE: begin
        if (do_insert) begin
          mem_we    = 1'b1;
          mem_waddr = free_slot_r;
          mem_wdata = {1'b1, key_r, val_r};
        end else if (do_remove) begin
          mem_we    = 1'b1;
          mem_waddr = slot_r;
        end
        state_nxt = lkv_pkg::S_DONE;
      end
      lkv_pkg::S_DONE: begin
        if (load_out) begin
          state_nxt = lkv_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lkv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scan / clear counter and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r      <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= mem_re;
      if (accept) begin
        sc_r <= '0;
      end else if (mem_re || state_r == lkv_pkg::S_CLEAR) begin
        sc_r <= sc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_idx_r <= sc_r[AW-1:0];
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      key_r <= in_key[KW-1:0];
      val_r <= in_value[VW-1:0];
    end
  end

  // shared compare: first match and lowest free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (accept) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (rd_pend_r) begin
      if (key_match && !found_r) begin
        found_r <= 1'b1;
      end
      if (!rd_used && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r && key_match && !found_r) begin
      slot_r <= rd_idx_r;
      fval_r <= rd_val;
    end
    if (rd_pend_r && !rd_used && !free_found_r) begin
      free_slot_r <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (state_r == lkv_pkg::S_UPDATE) begin
      if (do_insert) begin
        count_r <= count_r + 1'b1;
      end else if (do_remove) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // result formation
  always_comb begin
    res_status = lkv_pkg::STAT_OK;
    res_hit    = 1'b0;
    res_found  = '0;
    case (op_r)
      lkv_pkg::OP_INSERT: begin
        res_hit = found_r;
        if (found_r) begin
          res_status = lkv_pkg::STAT_DUPLICATE;
        end else if (!free_found_r) begin
          res_status = lkv_pkg::STAT_FULL;
        end
      end
      lkv_pkg::OP_LOOKUP: begin
        res_hit = found_r;
        if (found_r) begin
          res_found = FW'(fval_r);
        end else begin
          res_status = lkv_pkg::STAT_NOT_FOUND;
        end
      end
      lkv_pkg::OP_REMOVE: begin
        res_hit = found_r;
        if (!found_r) begin
          res_status = lkv_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        res_status = lkv_pkg::STAT_OK;
      end
    endcase
  end

  assign count_ext = EW'(count_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r      <= res_status;
      out_hit_r         <= res_hit;
      out_found_value_r <= res_found;
      out_entry_count_r <= count_ext[lkv_pkg::COUNT_FIELD_WIDTH-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hit         = out_hit_r;
  assign out_found_value = out_found_value_r;
  assign out_entry_count = out_entry_count_r;

endmodule

// ----- bench/linear_key_value_table_tb.sv -----
// ----------------------------------------------------------------------------
// linear_key_value_table_tb
// Drives insert, lookup and remove words into the key/value table and checks
// every result word against a behavioral copy of the table kept in a
// scoreboard. A short directed sequence covers the corner cases and a fill to
// capacity; random traffic then alternates fill-heavy and drain-heavy phases
// over a small key pool, with random idling on both channels.
// ----------------------------------------------------------------------------
module linear_key_value_table_tb;

  localparam int SLOTS = 16;
  localparam int KEY_POOL = 24;
  localparam int RANDOM_WORDS = 1125;
  localparam int SETTLE_CYCLES = 30;
  // op code 3 is not used by the block; it must leave the table untouched
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] found_value;
    logic [4:0]  entry_count;
  } kv_result_t;

  class kv_table_scoreboard;
    logic [31:0] key_mem[SLOTS];
    logic [31:0] value_mem[SLOTS];
    bit          slot_used[SLOTS];
    int unsigned held;
    kv_result_t  pending_results[$];
    int          errors;

    function void note_word(logic [1:0] op, logic [31:0] key, logic [31:0] value);
      kv_result_t r;
      int         match;
      int         free_slot;
      match = -1;
      free_slot = -1;
      r = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && key_mem[i] == key && match < 0) match = i;
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      case (op)
        lkv_pkg::OP_INSERT: begin
          // duplicate check wins over full check
          if (match >= 0) begin
            r.status = lkv_pkg::STAT_DUPLICATE;
            r.hit = 1'b1;
          end else if (free_slot < 0) begin
            r.status = lkv_pkg::STAT_FULL;
          end else begin
            key_mem[free_slot] = key;
            value_mem[free_slot] = value;
            slot_used[free_slot] = 1'b1;
            held++;
          end
        end
        lkv_pkg::OP_LOOKUP: begin
          if (match >= 0) begin
            r.hit = 1'b1;
            r.found_value = value_mem[match];
          end else begin
            r.status = lkv_pkg::STAT_NOT_FOUND;
          end
        end
        lkv_pkg::OP_REMOVE: begin
          if (match >= 0) begin
            r.hit = 1'b1;
            slot_used[match] = 1'b0;
            held--;
          end else begin
            r.status = lkv_pkg::STAT_NOT_FOUND;
          end
        end
        default: ;
      endcase
      r.entry_count = held[4:0];
      pending_results.push_back(r);
    endfunction

    function void field_mismatch(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    endfunction

    function void check_result(logic [1:0] status, logic hit, logic [31:0] found,
                               logic [4:0] count);
      kv_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing pending, expected none, actual %0d %0d %h %0d",
                 $time, status, hit, found, count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        field_mismatch("status", 32'(want.status), 32'(status));
      if (hit !== want.hit)
        field_mismatch("hit", 32'(want.hit), 32'(hit));
      if (found !== want.found_value)
        field_mismatch("found_value", want.found_value, found);
      if (count !== want.entry_count)
        field_mismatch("entry_count", 32'(want.entry_count), 32'(count));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = lkv_pkg::OP_LOOKUP;
  logic [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_hit;
  logic [31:0] out_found_value;
  logic [4:0]  out_entry_count;

  kv_table_scoreboard sb = new();
  logic [31:0] key_pool[KEY_POOL];
  bit          no_gap = 1'b0;
  int          results_taken = 0;

  linear_key_value_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // valid is only lowered during an idle gap, never in the step that raises it
  task automatic send_word(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    while (!no_gap && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key <= key;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(op, key, value);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_status, out_hit, out_found_value, out_entry_count);
        results_taken++;
        if (results_taken == 150) hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= (results_taken >= 320 && results_taken < 520) ||
                     ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    int          roll;
    bit          fill_phase;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_word(lkv_pkg::OP_LOOKUP, key_pool[0], $urandom);       // miss on empty table
    send_word(lkv_pkg::OP_REMOVE, key_pool[1], $urandom);       // remove of missing key
    send_word(lkv_pkg::OP_INSERT, key_pool[0], '0);
    send_word(lkv_pkg::OP_INSERT, key_pool[1], '1);
    send_word(lkv_pkg::OP_LOOKUP, key_pool[1], '0);
    send_word(lkv_pkg::OP_INSERT, key_pool[1], 32'h1234_5678);  // duplicate
    send_word(OP_UNUSED, $urandom, $urandom);
    send_word(lkv_pkg::OP_LOOKUP, key_pool[0], '1);
    send_word(lkv_pkg::OP_REMOVE, key_pool[1], '0);
    for (int i = 2; i < SLOTS + 1; i++) send_word(lkv_pkg::OP_INSERT, key_pool[i], $urandom);
    send_word(lkv_pkg::OP_INSERT, key_pool[SLOTS + 1], $urandom);  // table full
    send_word(lkv_pkg::OP_INSERT, key_pool[0], $urandom);          // duplicate beats full

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_gap = (n >= 300 && n < 500);
      fill_phase = ((n / 120) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 4) op = OP_UNUSED;
      else if (roll < (fill_phase ? 55 : 20)) op = lkv_pkg::OP_INSERT;
      else if (roll < (fill_phase ? 80 : 55)) op = lkv_pkg::OP_LOOKUP;
      else op = lkv_pkg::OP_REMOVE;

      roll = $urandom_range(99);
      key = key_pool[$urandom_range(KEY_POOL - 1)];
      // near-miss keys catch a comparator that ignores a bit
      if (roll >= 85) key = $urandom;
      else if (roll >= 70) key = key ^ (32'd1 << $urandom_range(31));

      roll = $urandom_range(99);
      if (roll < 5) value = '0;
      else if (roll < 10) value = '1;
      else value = $urandom;

      send_word(op, key, value);

      if (n == 700) begin
        in_valid <= 1'b0;
        wait_drained();
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
